/* rtl/static_linked_list_engine_unit_defines.svh */
// ---------------------------------------------------------------------------
// Static linked list engine assertion macros
// Shared property shorthands for the engine's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef STATIC_LINKED_LIST_ENGINE_UNIT_DEFINES_SVH
`define STATIC_LINKED_LIST_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define SLLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define SLLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/slle_pkg.sv */
// ---------------------------------------------------------------------------
// slle_pkg
// Types, codes and defaults shared by the static linked list engine.
// ---------------------------------------------------------------------------
package slle_pkg;

  // Default sizes.
  localparam int NODES_DEF      = 256;
  localparam int DATA_WIDTH_DEF = 32;

  // Operation codes.
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_GET    = 3'd2;
  localparam logic [2:0] OP_LOCATE = 3'd3;
  localparam logic [2:0] OP_LENGTH = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Controller states.
  typedef enum logic [4:0] {
    S_RST_INIT, S_CLR, S_IDLE, S_DECODE, S_WALK,
    S_I_RD0, S_I_F, S_I_FN, S_I_PN, S_I_LNK,
    S_D_K, S_D_KR, S_D_KN, S_D_F, S_D_REL,
    S_G_RD, S_G_V, S_L_K, S_L_CMP, S_DONE
  } st_t;

  // Datapath commands.
  typedef enum logic [4:0] {
    DC_NOP, DC_INIT, DC_LOAD, DC_ERR_MISS, DC_ERR_FULL,
    DC_WSTART_PRED, DC_WSTART_POS, DC_WALK,
    DC_I_RD0, DC_I_F, DC_I_FN, DC_I_PN, DC_I_LNK,
    DC_D_K, DC_D_KR, DC_D_KN, DC_D_F, DC_D_REL,
    DC_G_RD, DC_G_V, DC_L_START, DC_L_K, DC_L_CMP
  } dp_cmd_t;

  // Controller to datapath.
  typedef struct packed {
    dp_cmd_t op;
    logic    push;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [2:0] op;
    logic       bad_ins;
    logic       bad_pos;
    logic       full;
    logic       walk_done;
    logic       loc_hit;
    logic       loc_end;
    logic       lk_zero;
    logic       init_last;
    logic       out_busy;
  } dp_sts_t;

endpackage

/* rtl/slle_ram.sv */
// ---------------------------------------------------------------------------
// slle_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module slle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and a read that returns the old contents on collision.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/slle_ctrl.sv */
// ---------------------------------------------------------------------------
// slle_ctrl
// Sequencer for the list engine: walks each operation through its steps.
// ---------------------------------------------------------------------------
module slle_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  slle_pkg::dp_sts_t  sts,
  output slle_pkg::ctl_cmd_t cmd
);

  slle_pkg::st_t state_r, state_nxt;
  slle_pkg::st_t after_walk;

  // Where a finished walk continues.
  always_comb begin
    case (sts.op)
      slle_pkg::OP_INSERT: after_walk = slle_pkg::S_I_RD0;
      slle_pkg::OP_DELETE: after_walk = slle_pkg::S_D_K;
      default:             after_walk = slle_pkg::S_G_RD;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      slle_pkg::S_RST_INIT: if (sts.init_last) state_nxt = slle_pkg::S_IDLE;
      slle_pkg::S_CLR:      if (sts.init_last) state_nxt = slle_pkg::S_DONE;
      slle_pkg::S_IDLE:     if (in_valid) state_nxt = slle_pkg::S_DECODE;
      slle_pkg::S_DECODE: begin
        case (sts.op)
          slle_pkg::OP_INSERT: begin
            if (sts.bad_ins || sts.full) state_nxt = slle_pkg::S_DONE;
            else state_nxt = slle_pkg::S_WALK;
          end
          slle_pkg::OP_DELETE, slle_pkg::OP_GET: begin
            if (sts.bad_pos) state_nxt = slle_pkg::S_DONE;
            else state_nxt = slle_pkg::S_WALK;
          end
          slle_pkg::OP_LOCATE: state_nxt = slle_pkg::S_L_K;
          slle_pkg::OP_CLEAR:  state_nxt = slle_pkg::S_CLR;
          default:             state_nxt = slle_pkg::S_DONE;
        endcase
      end
      slle_pkg::S_WALK:  if (sts.walk_done) state_nxt = after_walk;
      slle_pkg::S_I_RD0: state_nxt = slle_pkg::S_I_F;
      slle_pkg::S_I_F:   state_nxt = slle_pkg::S_I_FN;
      slle_pkg::S_I_FN:  state_nxt = slle_pkg::S_I_PN;
      slle_pkg::S_I_PN:  state_nxt = slle_pkg::S_I_LNK;
      slle_pkg::S_I_LNK: state_nxt = slle_pkg::S_DONE;
      slle_pkg::S_D_K:   state_nxt = slle_pkg::S_D_KR;
      slle_pkg::S_D_KR:  state_nxt = slle_pkg::S_D_KN;
      slle_pkg::S_D_KN:  state_nxt = slle_pkg::S_D_F;
      slle_pkg::S_D_F:   state_nxt = slle_pkg::S_D_REL;
      slle_pkg::S_D_REL: state_nxt = slle_pkg::S_DONE;
      slle_pkg::S_G_RD:  state_nxt = slle_pkg::S_G_V;
      slle_pkg::S_G_V:   state_nxt = slle_pkg::S_DONE;
      slle_pkg::S_L_K: begin
        if (sts.lk_zero) state_nxt = slle_pkg::S_DONE;
        else state_nxt = slle_pkg::S_L_CMP;
      end
      slle_pkg::S_L_CMP: if (sts.loc_hit || sts.loc_end) state_nxt = slle_pkg::S_DONE;
      slle_pkg::S_DONE:  if (!sts.out_busy) state_nxt = slle_pkg::S_IDLE;
      default:           state_nxt = slle_pkg::S_RST_INIT;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd.op   = slle_pkg::DC_NOP;
    cmd.push = 1'b0;
    in_stall = 1'b1;
    case (state_r)
      slle_pkg::S_RST_INIT, slle_pkg::S_CLR: cmd.op = slle_pkg::DC_INIT;
      slle_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd.op = slle_pkg::DC_LOAD;
      end
      slle_pkg::S_DECODE: begin
        case (sts.op)
          slle_pkg::OP_INSERT: begin
            if (sts.bad_ins) cmd.op = slle_pkg::DC_ERR_MISS;
            else if (sts.full) cmd.op = slle_pkg::DC_ERR_FULL;
            else cmd.op = slle_pkg::DC_WSTART_PRED;
          end
          slle_pkg::OP_DELETE: begin
            if (sts.bad_pos) cmd.op = slle_pkg::DC_ERR_MISS;
            else cmd.op = slle_pkg::DC_WSTART_PRED;
          end
          slle_pkg::OP_GET: begin
            if (sts.bad_pos) cmd.op = slle_pkg::DC_ERR_MISS;
            else cmd.op = slle_pkg::DC_WSTART_POS;
          end
          slle_pkg::OP_LOCATE: cmd.op = slle_pkg::DC_L_START;
          slle_pkg::OP_LENGTH, slle_pkg::OP_CLEAR: cmd.op = slle_pkg::DC_NOP;
          default: cmd.op = slle_pkg::DC_ERR_MISS;
        endcase
      end
      slle_pkg::S_WALK:  cmd.op = slle_pkg::DC_WALK;
      slle_pkg::S_I_RD0: cmd.op = slle_pkg::DC_I_RD0;
      slle_pkg::S_I_F:   cmd.op = slle_pkg::DC_I_F;
      slle_pkg::S_I_FN:  cmd.op = slle_pkg::DC_I_FN;
      slle_pkg::S_I_PN:  cmd.op = slle_pkg::DC_I_PN;
      slle_pkg::S_I_LNK: cmd.op = slle_pkg::DC_I_LNK;
      slle_pkg::S_D_K:   cmd.op = slle_pkg::DC_D_K;
      slle_pkg::S_D_KR:  cmd.op = slle_pkg::DC_D_KR;
      slle_pkg::S_D_KN:  cmd.op = slle_pkg::DC_D_KN;
      slle_pkg::S_D_F:   cmd.op = slle_pkg::DC_D_F;
      slle_pkg::S_D_REL: cmd.op = slle_pkg::DC_D_REL;
      slle_pkg::S_G_RD:  cmd.op = slle_pkg::DC_G_RD;
      slle_pkg::S_G_V:   cmd.op = slle_pkg::DC_G_V;
      slle_pkg::S_L_K:   cmd.op = slle_pkg::DC_L_K;
      slle_pkg::S_L_CMP: cmd.op = slle_pkg::DC_L_CMP;
      slle_pkg::S_DONE:  cmd.push = !sts.out_busy;
      default:           cmd.op = slle_pkg::DC_NOP;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slle_pkg::S_RST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/slle_dpath.sv */
// ---------------------------------------------------------------------------
// slle_dpath
// Node stores, cursor registers, length counter and result register.
// ---------------------------------------------------------------------------
module slle_dpath #(
  parameter int NODES      = slle_pkg::NODES_DEF,
  parameter int DATA_WIDTH = slle_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  slle_pkg::ctl_cmd_t cmd,
  output slle_pkg::dp_sts_t  sts,
  input  logic [2:0]         in_operation,
  input  logic [7:0]         in_position,
  input  logic signed [31:0] in_value_in,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_compare_mode,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_value_out,
  output logic [7:0]         out_count
);

  localparam int AW = $clog2(NODES);
  localparam int CW = AW + 9;
  localparam int DW = DATA_WIDTH;

  // Work registers.
  logic [2:0]    op_r, op_nxt;
  logic [7:0]    pos_r, pos_nxt;
  logic [DW-1:0] val_r, val_nxt;
  logic          cmode_r, cmode_nxt;
  logic [AW-1:0] len_r, len_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic          pend_r, pend_nxt;
  logic [7:0]    remain_r, remain_nxt;
  logic [AW-1:0] f_r, f_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [AW-1:0] lcnt_r, lcnt_nxt;
  logic [AW-1:0] init_i_r, init_i_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [DW-1:0] vout_r, vout_nxt;
  logic          use_lcnt_r, use_lcnt_nxt;

  // Result register.
  logic          ovalid_r, ovalid_nxt;
  logic [1:0]    ostatus_r, ostatus_nxt;
  logic [31:0]   ovalue_r, ovalue_nxt;
  logic [7:0]    ocount_r, ocount_nxt;

  // Memory ports.
  logic          nx_we, vl_we;
  logic [AW-1:0] nx_waddr, nx_wdata, nx_raddr, nx_rdata;
  logic [AW-1:0] vl_waddr, vl_raddr;
  logic [DW-1:0] vl_rdata;

  logic [AW-1:0]    p_cur;
  logic [AW-1:0]    init_link;
  logic             hit;
  logic [DW+31:0]   val_ext;
  logic [DW+31:0]   vout_ext;
  logic [AW+7:0]    cnt_ext;

  slle_ram #(.WIDTH(AW), .DEPTH(NODES)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(nx_raddr), .rdata(nx_rdata)
  );

  slle_ram #(.WIDTH(DW), .DEPTH(NODES)) u_value (
    .clk(clk), .we(vl_we), .waddr(vl_waddr), .wdata(val_r),
    .raddr(vl_raddr), .rdata(vl_rdata)
  );

  // Cursor during a walk: last link read, or the start slot.
  assign p_cur = pend_r ? nx_rdata : ptr_r;

  // Link value of the free chain after reset or clear.
  always_comb begin
    if (init_i_r == '0) begin
      init_link = AW'(2);
    end else if (init_i_r == AW'(1) || init_i_r == AW'(NODES - 1)) begin
      init_link = '0;
    end else begin
      init_link = init_i_r + AW'(1);
    end
  end

  // Locate match rule.
  assign hit = cmode_r ? ($signed(vl_rdata) > $signed(val_r)) : (vl_rdata == val_r);

  // Width adaptation of values.
  assign val_ext  = {{DW{in_value_in[31]}}, in_value_in};
  assign vout_ext = {{32{vout_r[DW-1]}}, vout_r};
  assign cnt_ext  = use_lcnt_r ? (AW + 8)'(lcnt_r) : (AW + 8)'(len_r);

  // Status to the controller.
  always_comb begin
    sts.op        = op_r;
    sts.bad_ins   = (pos_r == 8'd0) || (CW'(pos_r) > (CW'(len_r) + CW'(1)));
    sts.bad_pos   = (pos_r == 8'd0) || (CW'(pos_r) > CW'(len_r));
    sts.full      = (len_r == AW'(NODES - 2));
    sts.walk_done = (remain_r == 8'd0);
    sts.loc_hit   = hit;
    sts.loc_end   = (nx_rdata == '0);
    sts.lk_zero   = (nx_rdata == '0);
    sts.init_last = (init_i_r == AW'(NODES - 1));
    sts.out_busy  = ovalid_r && out_stall;
  end

  assign cfg_ready = 1'b1;

  // Command decode and next values.
  always_comb begin
    op_nxt       = op_r;
    pos_nxt      = pos_r;
    val_nxt      = val_r;
    cmode_nxt    = cmode_r;
    len_nxt      = len_r;
    ptr_nxt      = ptr_r;
    pend_nxt     = pend_r;
    remain_nxt   = remain_r;
    f_nxt        = f_r;
    k_nxt        = k_r;
    lcnt_nxt     = lcnt_r;
    init_i_nxt   = init_i_r;
    status_nxt   = status_r;
    vout_nxt     = vout_r;
    use_lcnt_nxt = use_lcnt_r;
    nx_we        = 1'b0;
    nx_waddr     = '0;
    nx_wdata     = '0;
    nx_raddr     = '0;
    vl_we        = 1'b0;
    vl_waddr     = '0;
    vl_raddr     = '0;

    if (cfg_valid && cfg_ready) begin
      cmode_nxt = cfg_compare_mode;
    end

    case (cmd.op)
      slle_pkg::DC_INIT: begin
        nx_we      = 1'b1;
        nx_waddr   = init_i_r;
        nx_wdata   = init_link;
        init_i_nxt = sts.init_last ? '0 : init_i_r + AW'(1);
        len_nxt    = '0;
      end
      slle_pkg::DC_LOAD: begin
        op_nxt       = in_operation;
        pos_nxt      = in_position;
        val_nxt      = val_ext[DW-1:0];
        status_nxt   = slle_pkg::ST_OK;
        vout_nxt     = '0;
        use_lcnt_nxt = 1'b0;
      end
      slle_pkg::DC_ERR_MISS: status_nxt = slle_pkg::ST_MISS;
      slle_pkg::DC_ERR_FULL: status_nxt = slle_pkg::ST_FULL;
      slle_pkg::DC_WSTART_PRED: begin
        ptr_nxt    = AW'(1);
        pend_nxt   = 1'b0;
        remain_nxt = pos_r - 8'd1;
      end
      slle_pkg::DC_WSTART_POS: begin
        ptr_nxt    = AW'(1);
        pend_nxt   = 1'b0;
        remain_nxt = pos_r;
      end
      // One link per cycle: the read address follows the data just read.
      slle_pkg::DC_WALK: begin
        ptr_nxt = p_cur;
        if (sts.walk_done) begin
          pend_nxt = 1'b0;
        end else begin
          nx_raddr   = p_cur;
          pend_nxt   = 1'b1;
          remain_nxt = remain_r - 8'd1;
        end
      end
      // Insert: take the free head, splice it after the predecessor.
      slle_pkg::DC_I_RD0: nx_raddr = '0;
      slle_pkg::DC_I_F: begin
        f_nxt    = nx_rdata;
        nx_raddr = nx_rdata;
      end
      slle_pkg::DC_I_FN: begin
        nx_we    = 1'b1;
        nx_waddr = '0;
        nx_wdata = nx_rdata;
        nx_raddr = ptr_r;
      end
      slle_pkg::DC_I_PN: begin
        nx_we    = 1'b1;
        nx_waddr = f_r;
        nx_wdata = nx_rdata;
        vl_we    = 1'b1;
        vl_waddr = f_r;
      end
      slle_pkg::DC_I_LNK: begin
        nx_we    = 1'b1;
        nx_waddr = ptr_r;
        nx_wdata = f_r;
        len_nxt  = len_r + AW'(1);
      end
      // Delete: unlink the node after the predecessor, return it to the free chain.
      slle_pkg::DC_D_K: nx_raddr = ptr_r;
      slle_pkg::DC_D_KR: begin
        k_nxt    = nx_rdata;
        nx_raddr = nx_rdata;
        vl_raddr = nx_rdata;
      end
      slle_pkg::DC_D_KN: begin
        nx_we    = 1'b1;
        nx_waddr = ptr_r;
        nx_wdata = nx_rdata;
        vout_nxt = vl_rdata;
        nx_raddr = '0;
      end
      slle_pkg::DC_D_F: begin
        nx_we    = 1'b1;
        nx_waddr = k_r;
        nx_wdata = nx_rdata;
      end
      slle_pkg::DC_D_REL: begin
        nx_we    = 1'b1;
        nx_waddr = '0;
        nx_wdata = k_r;
        len_nxt  = len_r - AW'(1);
      end
      slle_pkg::DC_G_RD: vl_raddr = ptr_r;
      slle_pkg::DC_G_V:  vout_nxt = vl_rdata;
      // Locate: value and link of each node are read together.
      slle_pkg::DC_L_START: begin
        nx_raddr     = AW'(1);
        use_lcnt_nxt = 1'b1;
        lcnt_nxt     = '0;
        status_nxt   = slle_pkg::ST_MISS;
      end
      slle_pkg::DC_L_K: begin
        if (nx_rdata != '0) begin
          nx_raddr = nx_rdata;
          vl_raddr = nx_rdata;
          lcnt_nxt = AW'(1);
        end
      end
      slle_pkg::DC_L_CMP: begin
        if (hit) begin
          status_nxt = slle_pkg::ST_OK;
        end else if (nx_rdata != '0) begin
          nx_raddr = nx_rdata;
          vl_raddr = nx_rdata;
          lcnt_nxt = lcnt_r + AW'(1);
        end else begin
          lcnt_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register: loaded on push, freed by an output transfer.
  always_comb begin
    ovalid_nxt  = ovalid_r;
    ostatus_nxt = ostatus_r;
    ovalue_nxt  = ovalue_r;
    ocount_nxt  = ocount_r;
    if (ovalid_r && !out_stall) begin
      ovalid_nxt = 1'b0;
    end
    if (cmd.push) begin
      ovalid_nxt  = 1'b1;
      ostatus_nxt = status_r;
      ovalue_nxt  = vout_ext[31:0];
      ocount_nxt  = cnt_ext[7:0];
    end
  end

  // Control registers with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmode_r  <= 1'b0;
      len_r    <= '0;
      pend_r   <= 1'b0;
      init_i_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      cmode_r  <= cmode_nxt;
      len_r    <= len_nxt;
      pend_r   <= pend_nxt;
      init_i_r <= init_i_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    ptr_r      <= ptr_nxt;
    remain_r   <= remain_nxt;
    f_r        <= f_nxt;
    k_r        <= k_nxt;
    lcnt_r     <= lcnt_nxt;
    status_r   <= status_nxt;
    vout_r     <= vout_nxt;
    use_lcnt_r <= use_lcnt_nxt;
    ostatus_r  <= ostatus_nxt;
    ovalue_r   <= ovalue_nxt;
    ocount_r   <= ocount_nxt;
  end

  assign out_valid     = ovalid_r;
  assign out_status    = ostatus_r;
  assign out_value_out = $signed(ovalue_r);
  assign out_count     = ocount_r;

endmodule

/* rtl/static_linked_list_engine_unit.sv */
// ---------------------------------------------------------------------------
// static_linked_list_engine_unit
// Cursor-linked list in a fixed node store with a free chain, one result per
// operation.
// ---------------------------------------------------------------------------
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_stall   operation, position, value_in
//   out_     output     out_valid / out_stall status, value_out, count
//   cfg_     input      cfg_valid / cfg_ready compare_mode
//
// Locate reads one node per cycle of the link RAM read loop; the link RAM's
// single read port sets the walk rate. After reset a sweep over every node
// slot builds the free chain; no item is accepted until it ends. A stalled
// result waits in the output register while the next item is taken.
// ---------------------------------------------------------------------------
`include "static_linked_list_engine_unit_defines.svh"

module static_linked_list_engine_unit #(
  parameter int NODES      = slle_pkg::NODES_DEF,
  parameter int DATA_WIDTH = slle_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_operation,
  input  logic [7:0]         in_position,
  input  logic signed [31:0] in_value_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_value_out,
  output logic [7:0]         out_count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_compare_mode
);

  slle_pkg::ctl_cmd_t cmd;
  slle_pkg::dp_sts_t  sts;

  slle_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  slle_dpath #(.NODES(NODES), .DATA_WIDTH(DATA_WIDTH)) u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_operation(in_operation), .in_position(in_position),
    .in_value_in(in_value_in), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_compare_mode(cfg_compare_mode), .out_valid(out_valid),
    .out_stall(out_stall), .out_status(out_status),
    .out_value_out(out_value_out), .out_count(out_count)
  );

  // An accepted item keeps the input closed while it is worked on.
  `SLLE_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input open after accept")

  // A new result never overwrites one that is still waiting.
  `SLLE_ASSERT_IMP(a_no_overwrite, cmd.push, !(out_valid && out_stall), "result overwritten")

  // A full store is reported only for insert.
  `SLLE_ASSERT_IMP(a_full_insert, cmd.push && (sts.op != slle_pkg::OP_INSERT), u_dpath.status_r != slle_pkg::ST_FULL, "full status on non-insert")

endmodule
